/* sv/i2c_master_write_queue_macros.svh */
// Assertion macros for the I2C master write queue.
// Depends on nothing; included by the top level.
`ifndef I2C_MASTER_WRITE_QUEUE_MACROS_SVH
`define I2C_MASTER_WRITE_QUEUE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define I2CMWQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define I2CMWQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/i2cmwq_pkg.sv */
// Shared types and constants of the I2C master write queue.
// Depends on nothing; used by the controller, datapath, top level and testbench.
`default_nettype none

package i2cmwq_pkg;

  localparam int STREAM_DEPTH_DEF = 256;
  localparam int FRAME_DEPTH_DEF  = 64;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_SLAVE_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAP_TICKS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_MARKER  = 2'd3;

  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
  localparam logic [7:0]  MIN_GAP_RESET = 8'd4;
  localparam logic [7:0]  MARKER_RESET  = 8'd170;

  // Header overhead: marker, length and one spare entry.
  localparam int HDR_OVERHEAD = 3;

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_HEADER = 3'd1,
    OP_BYTE   = 3'd2,
    OP_EVENT  = 3'd3,
    OP_ERROR  = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_START = 3'd1,
    PH_ADDR  = 3'd2,
    PH_DATA  = 3'd3,
    PH_STOP  = 3'd4
  } phase_t;

  typedef enum logic [3:0] {
    C_IDLE,
    C_EXEC,
    C_JOB,
    C_HDR2,
    C_SKIP_RD,
    C_SKIP_CHK,
    C_LEN_RD,
    C_LEN,
    C_COPY_CHK,
    C_COPY_WR,
    C_FRAME_OUT,
    C_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic latch;
    logic tick_inc;
    logic set_timeout;
    logic set_enable;
    logic hdr_push1;
    logic hdr_reject;
    logic hdr_push2;
    logic byte_push;
    logic event_apply;
    logic frame_read;
    logic frame_out;
    logic error_apply;
    logic stream_read;
    logic len_load;
    logic copy_push;
    logic job_start;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic s_empty;
    logic busy;
    logic timed_out;
    logic gap_short;
    logic hdr_fits;
    logic byte_ok;
    logic evt_frame;
    logic rd_is_marker;
    logic copy_done;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

/* sv/i2cmwq_if.sv */
// Channel interfaces of the I2C master write queue: request and response.
// Depends on nothing.
`default_nettype none

interface i2cmwq_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic [7:0] payload;
  logic       start_flag;
  logic       address_flag;
  logic       byte_done_flag;
  logic       tx_empty_flag;

  modport source (output valid, operation, payload, start_flag, address_flag,
                  byte_done_flag, tx_empty_flag, input ready);
  modport sink (input valid, operation, payload, start_flag, address_flag,
                byte_done_flag, tx_empty_flag, output ready);
endinterface

interface i2cmwq_rsp_if;
  logic       valid;
  logic       ready;
  logic       accepted;
  logic       start_request;
  logic       stop_request;
  logic       data_valid;
  logic [7:0] data_byte;
  logic       ack_enable;
  logic       bus_enable;
  logic [2:0] phase;

  modport source (output valid, accepted, start_request, stop_request, data_valid,
                  data_byte, ack_enable, bus_enable, phase, input ready);
  modport sink (input valid, accepted, start_request, stop_request, data_valid,
                data_byte, ack_enable, bus_enable, phase, output ready);
endinterface

`default_nettype wire

/* sv/i2cmwq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module i2cmwq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* sv/i2cmwq_ctrl.sv */
// Sequencing state machine of the I2C master write queue.
// Depends on i2cmwq_pkg; drives the datapath through cmd_t.
`default_nettype none

module i2cmwq_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire i2cmwq_pkg::sts_t  sts,
  output logic                   in_ready,
  output i2cmwq_pkg::cmd_t       cmd
);

  i2cmwq_pkg::ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= i2cmwq_pkg::C_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      i2cmwq_pkg::C_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = i2cmwq_pkg::C_EXEC;
        end
      end
      i2cmwq_pkg::C_EXEC: begin
        state_next = i2cmwq_pkg::C_DONE;
        unique case (sts.op)
          i2cmwq_pkg::OP_TICK: begin
            cmd.tick_inc = 1'b1;
            state_next   = i2cmwq_pkg::C_JOB;
          end
          i2cmwq_pkg::OP_HEADER: begin
            if (sts.hdr_fits) begin
              cmd.hdr_push1 = 1'b1;
              state_next    = i2cmwq_pkg::C_HDR2;
            end else begin
              cmd.hdr_reject = 1'b1;
            end
          end
          i2cmwq_pkg::OP_BYTE: begin
            cmd.byte_push = sts.byte_ok;
          end
          i2cmwq_pkg::OP_EVENT: begin
            cmd.event_apply = 1'b1;
            if (sts.evt_frame) begin
              cmd.frame_read = 1'b1;
              state_next     = i2cmwq_pkg::C_FRAME_OUT;
            end
          end
          i2cmwq_pkg::OP_ERROR: begin
            cmd.error_apply = 1'b1;
          end
          default: begin
          end
        endcase
      end
      i2cmwq_pkg::C_JOB: begin
        state_next = i2cmwq_pkg::C_DONE;
        if (!sts.s_empty) begin
          if (sts.busy) begin
            cmd.set_timeout = sts.timed_out;
          end else begin
            cmd.set_enable = 1'b1;
            if (!sts.gap_short) begin
              state_next = i2cmwq_pkg::C_SKIP_RD;
            end
          end
        end
      end
      i2cmwq_pkg::C_HDR2: begin
        cmd.hdr_push2 = 1'b1;
        state_next    = i2cmwq_pkg::C_DONE;
      end
      i2cmwq_pkg::C_SKIP_RD: begin
        cmd.stream_read = 1'b1;
        state_next      = i2cmwq_pkg::C_SKIP_CHK;
      end
      i2cmwq_pkg::C_SKIP_CHK: begin
        priority if (sts.rd_is_marker && !sts.s_empty) begin
          state_next = i2cmwq_pkg::C_LEN_RD;
        end else if (sts.s_empty) begin
          state_next = i2cmwq_pkg::C_DONE;
        end else begin
          state_next = i2cmwq_pkg::C_SKIP_RD;
        end
      end
      i2cmwq_pkg::C_LEN_RD: begin
        cmd.stream_read = 1'b1;
        state_next      = i2cmwq_pkg::C_LEN;
      end
      i2cmwq_pkg::C_LEN: begin
        cmd.len_load = 1'b1;
        state_next   = i2cmwq_pkg::C_COPY_CHK;
      end
      i2cmwq_pkg::C_COPY_CHK: begin
        priority if (sts.copy_done) begin
          cmd.job_start = 1'b1;
          state_next    = i2cmwq_pkg::C_DONE;
        end else if (sts.s_empty) begin
          state_next = i2cmwq_pkg::C_DONE;
        end else begin
          cmd.stream_read = 1'b1;
          state_next      = i2cmwq_pkg::C_COPY_WR;
        end
      end
      i2cmwq_pkg::C_COPY_WR: begin
        cmd.copy_push = 1'b1;
        state_next    = i2cmwq_pkg::C_COPY_CHK;
      end
      i2cmwq_pkg::C_FRAME_OUT: begin
        cmd.frame_out = 1'b1;
        state_next    = i2cmwq_pkg::C_DONE;
      end
      i2cmwq_pkg::C_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = i2cmwq_pkg::C_IDLE;
        end
      end
      default: begin
        state_next = i2cmwq_pkg::C_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* sv/i2cmwq_dp.sv */
// Datapath of the I2C master write queue: config, stream and frame stores,
// bus state, timers and the output register. Depends on i2cmwq_pkg, i2cmwq_ram.
`default_nettype none

module i2cmwq_dp #(
  parameter int STREAM_DEPTH = i2cmwq_pkg::STREAM_DEPTH_DEF,
  parameter int FRAME_DEPTH  = i2cmwq_pkg::FRAME_DEPTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [i2cmwq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [i2cmwq_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic [2:0]                          in_operation,
  input  wire logic [7:0]                          in_payload,
  input  wire logic                                in_start,
  input  wire logic                                in_address,
  input  wire logic                                in_byte_done,
  input  wire logic                                in_tx_empty,
  input  wire i2cmwq_pkg::cmd_t                    cmd,
  output i2cmwq_pkg::sts_t                         sts,
  input  wire logic                                out_ready,
  output logic                                     out_valid,
  output logic                                     out_accepted,
  output logic                                     out_start,
  output logic                                     out_stop,
  output logic                                     out_dv,
  output logic [7:0]                               out_db,
  output logic                                     out_ack,
  output logic                                     out_enable,
  output logic [2:0]                               out_phase
);

  localparam int SAW = $clog2(STREAM_DEPTH);
  localparam int FAW = $clog2(FRAME_DEPTH);
  localparam int HW  = ((SAW > 8) ? SAW : 8) + 2;

  // configuration
  logic [6:0]  slave_address;
  logic [15:0] timeout_ticks;
  logic [7:0]  min_gap_ticks;
  logic [7:0]  block_marker;

  // latched item
  logic [2:0] item_op;
  logic [7:0] item_payload;
  logic       item_start;
  logic       item_address;
  logic       item_byte_done;
  logic       item_tx_empty;

  // bus and job state
  logic [SAW-1:0]       s_rptr;
  logic [SAW:0]         s_count;
  logic [FAW-1:0]       f_rptr;
  logic [FAW:0]         f_count;
  i2cmwq_pkg::phase_t   phase;
  logic [31:0]          tick_counter;
  logic [31:0]          activity_stamp;
  logic                 enabled;
  logic                 drop_rest;
  logic [7:0]           amount;
  logic [7:0]           copy_i;

  // pending result
  logic       res_acc;
  logic       res_start;
  logic       res_stop;
  logic       res_dv;
  logic [7:0] res_db;
  logic       res_ack;

  logic [7:0]     s_rdata;
  logic [7:0]     f_rdata;
  logic           s_we;
  logic [7:0]     s_wdata;
  logic [SAW:0]   s_wsum;
  logic [SAW-1:0] s_waddr;
  logic [FAW:0]   f_wsum;
  logic [FAW-1:0] f_waddr;
  logic           f_we;
  logic [31:0]    elapsed;
  logic [HW-1:0]  hdr_need;
  logic [SAW-1:0] s_rptr_inc;
  logic [FAW-1:0] f_rptr_inc;

  always_comb begin
    s_wsum  = {1'b0, s_rptr} + s_count;
    s_waddr = (s_wsum >= (SAW+1)'(STREAM_DEPTH)) ?
              SAW'(s_wsum - (SAW+1)'(STREAM_DEPTH)) : s_wsum[SAW-1:0];
    f_wsum  = {1'b0, f_rptr} + f_count;
    f_waddr = (f_wsum >= (FAW+1)'(FRAME_DEPTH)) ?
              FAW'(f_wsum - (FAW+1)'(FRAME_DEPTH)) : f_wsum[FAW-1:0];
    s_rptr_inc = (s_rptr == SAW'(STREAM_DEPTH - 1)) ? '0 : s_rptr + 1'b1;
    f_rptr_inc = (f_rptr == FAW'(FRAME_DEPTH - 1)) ? '0 : f_rptr + 1'b1;
    s_we    = cmd.hdr_push1 | cmd.hdr_push2 | cmd.byte_push;
    s_wdata = cmd.hdr_push1 ? block_marker : item_payload;
    f_we    = cmd.copy_push && (f_count < (FAW+1)'(FRAME_DEPTH));
    elapsed = tick_counter - activity_stamp;
    hdr_need = HW'(s_count) + HW'(item_payload) + HW'(i2cmwq_pkg::HDR_OVERHEAD);
  end

  always_comb begin
    sts.op           = i2cmwq_pkg::op_t'(item_op);
    sts.s_empty      = (s_count == '0);
    sts.busy         = (phase != i2cmwq_pkg::PH_IDLE);
    sts.timed_out    = (elapsed > {16'd0, timeout_ticks});
    sts.gap_short    = (elapsed < {24'd0, min_gap_ticks});
    sts.hdr_fits     = (hdr_need <= HW'(STREAM_DEPTH));
    sts.byte_ok      = !drop_rest && (s_count < (SAW+1)'(STREAM_DEPTH));
    sts.evt_frame    = !item_start && !item_address && !item_byte_done &&
                       item_tx_empty && (f_count != '0);
    sts.rd_is_marker = (s_rdata == block_marker);
    sts.copy_done    = (copy_i == amount);
    sts.out_free     = !out_valid || out_ready;
  end

  i2cmwq_ram #(.WIDTH(8), .DEPTH(STREAM_DEPTH)) u_stream_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_rptr),
    .rdata (s_rdata)
  );

  i2cmwq_ram #(.WIDTH(8), .DEPTH(FRAME_DEPTH)) u_frame_ram (
    .clk   (clk),
    .we    (f_we),
    .waddr (f_waddr),
    .wdata (s_rdata),
    .raddr (f_rptr),
    .rdata (f_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address  <= '0;
      timeout_ticks  <= i2cmwq_pkg::TIMEOUT_RESET;
      min_gap_ticks  <= i2cmwq_pkg::MIN_GAP_RESET;
      block_marker   <= i2cmwq_pkg::MARKER_RESET;
      s_rptr         <= '0;
      s_count        <= '0;
      f_rptr         <= '0;
      f_count        <= '0;
      phase          <= i2cmwq_pkg::PH_IDLE;
      tick_counter   <= '0;
      activity_stamp <= '0;
      enabled        <= 1'b1;
      drop_rest      <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          i2cmwq_pkg::CFG_SLAVE_ADDRESS: slave_address <= cfg_data[6:0];
          i2cmwq_pkg::CFG_TIMEOUT_TICKS: timeout_ticks <= cfg_data[15:0];
          i2cmwq_pkg::CFG_MIN_GAP_TICKS: min_gap_ticks <= cfg_data[7:0];
          i2cmwq_pkg::CFG_BLOCK_MARKER:  block_marker  <= cfg_data[7:0];
          default: begin
          end
        endcase
      end
      if (s_we) begin
        s_count <= s_count + 1'b1;
      end
      if (cmd.stream_read) begin
        s_rptr  <= s_rptr_inc;
        s_count <= s_count - 1'b1;
      end
      if (f_we) begin
        f_count <= f_count + 1'b1;
      end
      if (cmd.frame_read) begin
        f_rptr  <= f_rptr_inc;
        f_count <= f_count - 1'b1;
      end
      if (cmd.tick_inc) begin
        tick_counter <= tick_counter + 32'd1;
      end
      if (cmd.hdr_push1) begin
        drop_rest <= 1'b0;
      end
      if (cmd.hdr_reject) begin
        drop_rest <= 1'b1;
      end
      if (cmd.set_timeout) begin
        enabled <= 1'b0;
        phase   <= i2cmwq_pkg::PH_IDLE;
      end
      if (cmd.set_enable) begin
        enabled <= 1'b1;
      end
      if (cmd.job_start) begin
        phase <= i2cmwq_pkg::PH_START;
      end
      if (cmd.error_apply) begin
        phase          <= i2cmwq_pkg::PH_IDLE;
        activity_stamp <= tick_counter;
      end
      if (cmd.event_apply) begin
        activity_stamp <= tick_counter;
        priority if (item_start) begin
          phase <= i2cmwq_pkg::PH_ADDR;
        end else if (item_address) begin
          phase <= (f_count == '0) ? i2cmwq_pkg::PH_IDLE : i2cmwq_pkg::PH_DATA;
        end else if (item_byte_done) begin
          phase <= i2cmwq_pkg::PH_IDLE;
        end else if (item_tx_empty && (f_count == '0)) begin
          phase <= i2cmwq_pkg::PH_STOP;
        end else begin
        end
      end
      if (cmd.frame_out) begin
        phase <= i2cmwq_pkg::PH_DATA;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_op        <= in_operation;
      item_payload   <= in_payload;
      item_start     <= in_start;
      item_address   <= in_address;
      item_byte_done <= in_byte_done;
      item_tx_empty  <= in_tx_empty;
      res_acc        <= 1'b0;
      res_start      <= 1'b0;
      res_stop       <= 1'b0;
      res_dv         <= 1'b0;
      res_db         <= '0;
      res_ack        <= 1'b0;
    end
    if (cmd.hdr_push1 || cmd.byte_push) begin
      res_acc <= 1'b1;
    end
    if (cmd.job_start) begin
      res_start <= 1'b1;
    end
    if (cmd.len_load) begin
      amount <= s_rdata;
      copy_i <= '0;
    end
    if (cmd.copy_push) begin
      copy_i <= copy_i + 8'd1;
    end
    if (cmd.event_apply) begin
      priority if (item_start) begin
        res_ack <= 1'b1;
        res_dv  <= 1'b1;
        res_db  <= {slave_address, 1'b0};
      end else if (item_address) begin
        res_stop <= (f_count == '0);
        res_ack  <= (f_count != '0);
      end else if (item_byte_done) begin
        res_stop <= 1'b1;
      end else if (item_tx_empty && (f_count == '0)) begin
        res_stop <= 1'b1;
      end else begin
      end
    end
    if (cmd.frame_out) begin
      res_ack <= 1'b1;
      res_dv  <= 1'b1;
      res_db  <= f_rdata;
    end
    if (cmd.load_out) begin
      out_accepted <= res_acc;
      out_start    <= res_start;
      out_stop     <= res_stop;
      out_dv       <= res_dv;
      out_db       <= res_db;
      out_ack      <= res_ack;
      out_enable   <= enabled;
      out_phase    <= phase;
    end
  end

endmodule

`default_nettype wire

/* sv/i2c_master_write_queue.sv */
// Top level of the I2C master write queue: controller, datapath and checks.
// Depends on i2cmwq_pkg, i2cmwq_if, i2cmwq_ctrl, i2cmwq_dp and the macro header.
`default_nettype none
`include "i2c_master_write_queue_macros.svh"

// Queues I2C master write messages and sequences a bus master through them.
// Each request word (tick, header, message byte, bus event, bus error) yields
// exactly one response word. One word is in work at a time; a finished
// response waits in the output register while the next request is taken.
// A byte, an error, a rejected header, an unknown operation and most bus
// events go from the execute state to the done state; an accepted header
// adds a second push state and a bus event that sends a frame byte adds a
// frame-out state. A tick adds a job state; if the job scans the stream it
// skips bytes up to the marker, reads the length and copies message bytes
// to the frame buffer until the length is met or the stream runs dry. The
// stream memory has one registered read port, so each popped byte has a read
// state and a check or copy state. The done state holds while a response word
// still waits in the output register. Both stores are plain memories with no
// reset and no clearing pass; only written entries are ever read.
// Configuration writes may come at any time the block is idle.
module i2c_master_write_queue #(
  parameter int STREAM_DEPTH = i2cmwq_pkg::STREAM_DEPTH_DEF,
  parameter int FRAME_DEPTH  = i2cmwq_pkg::FRAME_DEPTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  i2cmwq_req_if.sink                             req,
  i2cmwq_rsp_if.source                           rsp,
  input  wire logic                              cfg_we,
  input  wire logic [i2cmwq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [i2cmwq_pkg::CFG_DATA_W-1:0] cfg_data
);

  i2cmwq_pkg::cmd_t cmd;
  i2cmwq_pkg::sts_t sts;
  logic             in_ready;

  // Controller: one state per step of each request word's handling.
  i2cmwq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .sts      (sts),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  assign req.ready = in_ready;

  // Datapath: stores, pointers, timers and the response register.
  i2cmwq_dp #(
    .STREAM_DEPTH (STREAM_DEPTH),
    .FRAME_DEPTH  (FRAME_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_operation (req.operation),
    .in_payload   (req.payload),
    .in_start     (req.start_flag),
    .in_address   (req.address_flag),
    .in_byte_done (req.byte_done_flag),
    .in_tx_empty  (req.tx_empty_flag),
    .cmd          (cmd),
    .sts          (sts),
    .out_ready    (rsp.ready),
    .out_valid    (rsp.valid),
    .out_accepted (rsp.accepted),
    .out_start    (rsp.start_request),
    .out_stop     (rsp.stop_request),
    .out_dv       (rsp.data_valid),
    .out_db       (rsp.data_byte),
    .out_ack      (rsp.ack_enable),
    .out_enable   (rsp.bus_enable),
    .out_phase    (rsp.phase)
  );

  // One word in work at a time: no accept right after an accept.
  `I2CMWQ_ASSERT_NEXT(a_one_in_work, clk, rst, req.valid && req.ready, !req.ready, "second word taken while one is in work")
  // A data byte always goes out with the acknowledge enable set.
  `I2CMWQ_ASSERT_NOW(a_dv_ack, clk, rst, rsp.valid && rsp.data_valid, rsp.ack_enable, "data without ack enable")
  // A start request leaves the controller in the start phase.
  `I2CMWQ_ASSERT_NOW(a_start_phase, clk, rst, rsp.valid && rsp.start_request, rsp.phase == i2cmwq_pkg::PH_START, "start request outside start phase")
  // A stored word never carries a bus request.
  `I2CMWQ_ASSERT_NOW(a_acc_quiet, clk, rst, rsp.valid && rsp.accepted, !rsp.start_request && !rsp.stop_request && !rsp.data_valid, "bus request on a stored word")

endmodule

`default_nettype wire

/* dv/i2c_master_write_queue_tb.sv */
// Testbench for the I2C master write queue: directed and random request words,
// a cycle-free predictor of every response word, and field-by-field checking.
// Depends on i2cmwq_pkg, i2cmwq_if and the i2c_master_write_queue top level.
`default_nettype none

module i2c_master_write_queue_tb;

  typedef struct packed {
    logic       accepted;
    logic       start_request;
    logic       stop_request;
    logic       data_valid;
    logic [7:0] data_byte;
    logic       ack_enable;
    logic       bus_enable;
    logic [2:0] phase;
  } resp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [i2cmwq_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [i2cmwq_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  i2cmwq_req_if req ();
  i2cmwq_rsp_if rsp ();

  i2c_master_write_queue dut (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // Predictor state: a copy of the block's queues, counters and registers.
  logic [7:0]  strm [256];
  int unsigned strm_rd, strm_cnt;
  logic [7:0]  frm [64];
  int unsigned frm_rd, frm_cnt;
  logic [2:0]  ph;
  logic [31:0] ticks, stamp, gap;
  logic        bus_en, dropping;
  logic [6:0]  addr_reg;
  logic [15:0] timeout_reg;
  logic [7:0]  min_gap_reg, marker_reg;

  resp_t expected_words[$];
  int errors = 0;
  int idle_cycles = 0;
  bit draining = 0;
  bit rx_hold = 0;
  bit no_idle = 0;

  function automatic logic [7:0] strm_pop();
    logic [7:0] v;
    v = strm[strm_rd];
    strm_rd = (strm_rd + 1) % 256;
    strm_cnt--;
    return v;
  endfunction

  // Run the millisecond job; return 1 when a START is requested.
  function automatic bit run_tick();
    int unsigned amount;
    ticks++;
    if (strm_cnt == 0) return 0;
    gap = ticks - stamp;
    if (ph != i2cmwq_pkg::PH_IDLE) begin
      if (gap > timeout_reg) begin
        bus_en = 1'b0;
        ph = i2cmwq_pkg::PH_IDLE;
      end
      return 0;
    end
    bus_en = 1'b1;
    if (gap < min_gap_reg) return 0;
    while (strm_pop() != marker_reg) begin
      if (strm_cnt == 0) return 0;
    end
    if (strm_cnt == 0) return 0;
    amount = strm_pop();
    for (int i = 0; i < amount; i++) begin
      if (strm_cnt == 0) return 0;
      if (frm_cnt < 64) begin
        frm[(frm_rd + frm_cnt) % 64] = strm_pop();
        frm_cnt++;
      end else begin
        void'(strm_pop());
      end
    end
    ph = i2cmwq_pkg::PH_START;
    return 1;
  endfunction

  function automatic void strm_push(logic [7:0] v);
    strm[(strm_rd + strm_cnt) % 256] = v;
    strm_cnt++;
  endfunction

  function automatic resp_t predict_word(logic [2:0] op, logic [7:0] pay, logic [3:0] fl);
    resp_t r;
    r = '0;
    case (op)
      i2cmwq_pkg::OP_TICK: r.start_request = run_tick();
      i2cmwq_pkg::OP_HEADER: begin
        if (256 - strm_cnt >= 3 + pay) begin
          strm_push(marker_reg);
          strm_push(pay);
          dropping = 1'b0;
          r.accepted = 1'b1;
        end else begin
          dropping = 1'b1;
        end
      end
      i2cmwq_pkg::OP_BYTE: begin
        if (!dropping && strm_cnt < 256) begin
          strm_push(pay);
          r.accepted = 1'b1;
        end
      end
      i2cmwq_pkg::OP_EVENT: begin
        stamp = ticks;
        if (fl[3]) begin
          r.ack_enable = 1'b1;
          r.data_valid = 1'b1;
          r.data_byte = {addr_reg, 1'b0};
          ph = i2cmwq_pkg::PH_ADDR;
        end else if (fl[2]) begin
          if (frm_cnt == 0) begin
            r.stop_request = 1'b1;
            ph = i2cmwq_pkg::PH_IDLE;
          end else begin
            r.ack_enable = 1'b1;
            ph = i2cmwq_pkg::PH_DATA;
          end
        end else if (fl[1]) begin
          r.stop_request = 1'b1;
          ph = i2cmwq_pkg::PH_IDLE;
        end else if (fl[0]) begin
          if (frm_cnt != 0) begin
            r.ack_enable = 1'b1;
            r.data_valid = 1'b1;
            r.data_byte = frm[frm_rd];
            frm_rd = (frm_rd + 1) % 64;
            frm_cnt--;
            ph = i2cmwq_pkg::PH_DATA;
          end else begin
            r.stop_request = 1'b1;
            ph = i2cmwq_pkg::PH_STOP;
          end
        end
      end
      i2cmwq_pkg::OP_ERROR: begin
        ph = i2cmwq_pkg::PH_IDLE;
        stamp = ticks;
      end
      default: ;
    endcase
    r.bus_enable = bus_en;
    r.phase = ph;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    errors++;
  endtask

  // Offer one request word; predict at the accepting edge.
  task automatic send_word(logic [2:0] op, logic [7:0] pay, logic [3:0] fl);
    if (!no_idle) begin
      while ($urandom_range(99) < 10) @(negedge clk);
    end
    req.valid <= 1'b1;
    req.operation <= op;
    req.payload <= pay;
    {req.start_flag, req.address_flag, req.byte_done_flag, req.tx_empty_flag} <= fl;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    expected_words.push_back(predict_word(op, pay, fl));
    @(negedge clk);
    req.valid <= 1'b0;
    @(negedge clk);
  endtask

  // Wait for all expected words, then let a tick's worst latency pass.
  task automatic drain();
    draining = 1;
    while (expected_words.size() != 0) @(negedge clk);
    repeat (600) @(negedge clk);
    draining = 0;
  endtask

  task automatic write_reg(logic [i2cmwq_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    case (idx)
      i2cmwq_pkg::CFG_SLAVE_ADDRESS: addr_reg = val[6:0];
      i2cmwq_pkg::CFG_TIMEOUT_TICKS: timeout_reg = val;
      i2cmwq_pkg::CFG_MIN_GAP_TICKS: min_gap_reg = val[7:0];
      i2cmwq_pkg::CFG_BLOCK_MARKER:  marker_reg = val[7:0];
      default: ;
    endcase
  endtask

  // Queue one message: header then its bytes.
  task automatic send_message(int len);
    send_word(i2cmwq_pkg::OP_HEADER, len[7:0], 4'b0);
    for (int i = 0; i < len; i++)
      send_word(i2cmwq_pkg::OP_BYTE, 8'($urandom_range(255)), 4'b0);
  endtask

  // Walk the bus through a whole frame: start, address, then bytes until stop.
  task automatic run_frame(int nbytes);
    send_word(i2cmwq_pkg::OP_EVENT, 8'd0, 4'b1000);
    send_word(i2cmwq_pkg::OP_EVENT, 8'd0, 4'b0100);
    for (int i = 0; i < nbytes; i++) send_word(i2cmwq_pkg::OP_EVENT, 8'd0, 4'b0001);
    send_word(i2cmwq_pkg::OP_EVENT, 8'd0, 4'b0010);
  endtask

  // Response side: random stalls, and a long hold-off when asked.
  always @(negedge clk) begin
    if (rst) rsp.ready <= 1'b0;
    else rsp.ready <= !rx_hold && (no_idle || $urandom_range(99) >= 10);
  end

  always @(posedge clk) begin
    resp_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word", 1, 0);
      end else begin
        want = expected_words.pop_front();
        if (rsp.accepted !== want.accepted)
          report_mismatch("accepted", rsp.accepted, want.accepted);
        if (rsp.start_request !== want.start_request)
          report_mismatch("start_request", rsp.start_request, want.start_request);
        if (rsp.stop_request !== want.stop_request)
          report_mismatch("stop_request", rsp.stop_request, want.stop_request);
        if (rsp.data_valid !== want.data_valid)
          report_mismatch("data_valid", rsp.data_valid, want.data_valid);
        if (rsp.data_byte !== want.data_byte)
          report_mismatch("data_byte", rsp.data_byte, want.data_byte);
        if (rsp.ack_enable !== want.ack_enable)
          report_mismatch("ack_enable", rsp.ack_enable, want.ack_enable);
        if (rsp.bus_enable !== want.bus_enable)
          report_mismatch("bus_enable", rsp.bus_enable, want.bus_enable);
        if (rsp.phase !== want.phase)
          report_mismatch("phase", rsp.phase, want.phase);
      end
    end
  end

  // Watchdog: count cycles in which neither side moves a word.
  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || rst || rx_hold)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic test_directed();
    send_word(i2cmwq_pkg::OP_TICK, 8'd0, 4'b0);     // empty stream: nothing happens
    send_word(3'd5, 8'hFF, 4'hF);                    // unknown operations
    send_word(3'd7, 8'h00, 4'h0);
    send_word(i2cmwq_pkg::OP_EVENT, 8'd0, 4'b0000);  // event with no flag
    send_message(3);
    repeat (5) send_word(i2cmwq_pkg::OP_TICK, 8'd0, 4'b0);
    run_frame(3);
    send_word(i2cmwq_pkg::OP_EVENT, 8'd0, 4'b0001);  // tx empty with empty frame
    send_word(i2cmwq_pkg::OP_HEADER, 8'd255, 4'b0);  // rejected: drop bytes after it
    send_word(i2cmwq_pkg::OP_BYTE, 8'd255, 4'b0);
    send_word(i2cmwq_pkg::OP_ERROR, 8'd0, 4'b0);
    send_message(0);
    send_word(i2cmwq_pkg::OP_BYTE, 8'd0, 4'b0);      // stray byte to skip
    drain();
  endtask

  task automatic test_config_extremes();
    write_reg(i2cmwq_pkg::CFG_SLAVE_ADDRESS, 16'd127);
    write_reg(i2cmwq_pkg::CFG_TIMEOUT_TICKS, 16'd1);
    write_reg(i2cmwq_pkg::CFG_MIN_GAP_TICKS, 16'd0);
    write_reg(i2cmwq_pkg::CFG_BLOCK_MARKER, 16'd0);
    send_message(2);
    send_word(i2cmwq_pkg::OP_TICK, 8'd0, 4'b0);
    send_word(i2cmwq_pkg::OP_EVENT, 8'd0, 4'b1000);
    send_message(1);
    repeat (4) send_word(i2cmwq_pkg::OP_TICK, 8'd0, 4'b0);  // busy past timeout
    send_word(i2cmwq_pkg::OP_HEADER, 8'd3, 4'b0);          // stream ends early
    send_word(i2cmwq_pkg::OP_BYTE, 8'd9, 4'b0);
    send_word(i2cmwq_pkg::OP_TICK, 8'd0, 4'b0);
    drain();
  endtask

  // Queue message bytes while the receiver holds off, then release it.
  task automatic test_backpressure();
    write_reg(i2cmwq_pkg::CFG_MIN_GAP_TICKS, 16'd255);
    write_reg(i2cmwq_pkg::CFG_BLOCK_MARKER, 16'd170);
    fork
      begin
        rx_hold = 1;
        repeat (3000) @(negedge clk);
        rx_hold = 0;
      end
      for (int i = 0; i < 60; i++)
        send_word(i2cmwq_pkg::OP_BYTE, 8'($urandom_range(255)), 4'b0);
    join
    drain();
  endtask

  // Frame buffer overflow: long messages copied without sending.
  task automatic test_frame_full();
    write_reg(i2cmwq_pkg::CFG_MIN_GAP_TICKS, 16'd0);
    write_reg(i2cmwq_pkg::CFG_TIMEOUT_TICKS, 16'd65535);
    for (int m = 0; m < 2; m++) begin
      send_message(40);
      send_word(i2cmwq_pkg::OP_TICK, 8'd0, 4'b0);
      send_word(i2cmwq_pkg::OP_ERROR, 8'd0, 4'b0);
    end
    drain();
  endtask

  task automatic test_random();
    int n;
    int r;
    int len;
    int nt;
    int nb;
    n = 0;
    for (int s = 0; s < 6; s++) begin
      write_reg(i2cmwq_pkg::CFG_SLAVE_ADDRESS, 16'($urandom_range(127)));
      write_reg(i2cmwq_pkg::CFG_TIMEOUT_TICKS,
                (s == 0) ? 16'd65535 : 16'($urandom_range(40, 1)));
      write_reg(i2cmwq_pkg::CFG_MIN_GAP_TICKS,
                (s == 1) ? 16'd255 : 16'($urandom_range(6)));
      write_reg(i2cmwq_pkg::CFG_BLOCK_MARKER,
                (s == 2) ? 16'd255 : 16'($urandom_range(255)));
      no_idle = (s == 3);
      while (n < (s + 1) * 295) begin
        r = $urandom_range(99);
        if (r < 55) begin
          // Well-formed exchange: message, ticks, bus walk.
          len = $urandom_range(6);
          nt = $urandom_range(8, 1);
          nb = $urandom_range(7);
          send_message(len);
          repeat (nt) send_word(i2cmwq_pkg::OP_TICK, 8'd0, 4'b0);
          run_frame(nb);
          n += len + nt + nb + 4;
        end else if (r < 90) begin
          send_word(3'($urandom_range(4)), 8'($urandom_range(255)),
                    4'($urandom_range(15)));
          n++;
        end else begin
          send_word(3'($urandom_range(7)), 8'($urandom_range(255)),
                    4'($urandom_range(15)));
          n++;
        end
      end
      drain();                                 // sender waits out all results
    end
    no_idle = 0;
  endtask

  initial begin
    req.valid = 1'b0;
    req.operation = '0;
    req.payload = '0;
    req.start_flag = 1'b0;
    req.address_flag = 1'b0;
    req.byte_done_flag = 1'b0;
    req.tx_empty_flag = 1'b0;
    strm_rd = 0; strm_cnt = 0; frm_rd = 0; frm_cnt = 0;
    ph = i2cmwq_pkg::PH_IDLE; ticks = 0; stamp = 0; bus_en = 1'b1; dropping = 1'b0;
    addr_reg = '0; timeout_reg = i2cmwq_pkg::TIMEOUT_RESET;
    min_gap_reg = i2cmwq_pkg::MIN_GAP_RESET; marker_reg = i2cmwq_pkg::MARKER_RESET;
    repeat (11) @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_config_extremes();
    test_backpressure();
    test_frame_full();
    test_random();
    if (errors == 0 && expected_words.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* i2c_master_write_queue.f */
+incdir+sv
sv/i2cmwq_pkg.sv
sv/i2cmwq_if.sv
sv/i2cmwq_ram.sv
sv/i2cmwq_ctrl.sv
sv/i2cmwq_dp.sv
sv/i2c_master_write_queue.sv
dv/i2c_master_write_queue_tb.sv
